// ----- rtl/fcull_pkg.sv -----
// ----------------------------------------------------------------------------
// fcull_pkg
// Shared sizes, register indexes and types for the frustum cull test block.
// ----------------------------------------------------------------------------
package fcull_pkg;

    // Build-time sizes
    localparam int MAX_PLANES     = 6;
    localparam int COORD_WIDTH    = 16;
    localparam int NUM_PLANE_REGS = 6;
    localparam int NUM_LANES      = (MAX_PLANES < NUM_PLANE_REGS) ? MAX_PLANES : NUM_PLANE_REGS;

    // Plane register layout: nx, ny, nz Q1.14 then d Q11.4, low to high
    localparam int NORM_WIDTH = 16;
    localparam int NORM_FRAC  = 14;
    localparam int PLANE_WIDTH = 4 * NORM_WIDTH;

    // Datapath widths
    localparam int PROD_WIDTH = COORD_WIDTH + NORM_WIDTH;
    localparam int ACC_RAW    = COORD_WIDTH + NORM_WIDTH + 4;
    localparam int ACC_WIDTH  = (ACC_RAW > NORM_WIDTH + NORM_FRAC + 2) ? ACC_RAW
                                                                       : NORM_WIDTH + NORM_FRAC + 2;

    // Configuration register indexes
    localparam int CFG_INDEX_WIDTH = 3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PLANE_COUNT = CFG_INDEX_WIDTH'(NUM_PLANE_REGS);
    localparam int COUNT_WIDTH = 3;
    localparam logic [COUNT_WIDTH-1:0] COUNT_RESET = 3'd6;

    // Operation codes
    localparam logic OP_SPHERE = 1'b0;
    localparam logic OP_BOX    = 1'b1;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [NORM_WIDTH-1:0]  norm_t;
    typedef logic        [PROD_WIDTH-1:0]  uprod_t;
    typedef logic signed [PROD_WIDTH-1:0]  sprod_t;
    typedef logic signed [ACC_WIDTH-1:0]   acc_t;

endpackage

// ----- rtl/frustum_cull_test_top.sv -----
// ----------------------------------------------------------------------------
// frustum_cull_test_top
// Tests a point, sphere or axis aligned box against up to six planes and
// reports whether it may be visible. One object is taken per clock cycle:
// busy never rises, so start may stay high on every cycle. Each result comes
// out on visible with done high for one cycle, after the object has passed
// the input register, the product register behind the per-plane multipliers
// and the result register. The receiver cannot stall, so results must be
// taken as they appear. The user must write planes and plane_count through
// the cfg port only while no object is in flight; the block does not
// enforce this. cfg_ready is always high.
// ----------------------------------------------------------------------------
module frustum_cull_test_top
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // object channel
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 op,
    input  fcull_pkg::coord_t                    center_x,
    input  fcull_pkg::coord_t                    center_y,
    input  fcull_pkg::coord_t                    center_z,
    input  fcull_pkg::coord_t                    radius,
    input  fcull_pkg::coord_t                    half_x,
    input  fcull_pkg::coord_t                    half_y,
    input  fcull_pkg::coord_t                    half_z,
    // result channel
    output logic                                 done,
    output logic                                 visible,
    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [fcull_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [fcull_pkg::PLANE_WIDTH-1:0]     cfg_data
);

    localparam int NL = fcull_pkg::NUM_LANES;
    localparam int NW = fcull_pkg::NORM_WIDTH;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [fcull_pkg::PLANE_WIDTH-1:0] plane_reg [NL];
    logic [fcull_pkg::COUNT_WIDTH-1:0] plane_count_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NL; i++)
            begin
                plane_reg[i] <= '0;
            end
            plane_count_reg <= fcull_pkg::COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            for (int i = 0; i < NL; i++)
            begin
                if (cfg_index == fcull_pkg::CFG_INDEX_WIDTH'(i))
                begin
                    plane_reg[i] <= cfg_data;
                end
            end
            if (cfg_index == fcull_pkg::CFG_PLANE_COUNT)
            begin
                plane_count_reg <= cfg_data[fcull_pkg::COUNT_WIDTH-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: input register
    // ------------------------------------------------------------------
    logic              s0_valid_reg;
    logic              s0_op_reg;
    fcull_pkg::coord_t s0_c_reg [3];
    fcull_pkg::coord_t s0_h_reg [3];
    fcull_pkg::coord_t s0_r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            s0_op_reg   <= op;
            s0_c_reg[0] <= center_x;
            s0_c_reg[1] <= center_y;
            s0_c_reg[2] <= center_z;
            s0_h_reg[0] <= half_x;
            s0_h_reg[1] <= half_y;
            s0_h_reg[2] <= half_z;
            s0_r_reg    <= radius;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: per-plane products
    // ------------------------------------------------------------------
    logic [fcull_pkg::COORD_WIDTH-1:0] habs [3];
    fcull_pkg::sprod_t dterm_next [NL][3];
    fcull_pkg::uprod_t bterm_next [NL][3];
    logic [NL-1:0]     mask_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            habs[k] = s0_h_reg[k][fcull_pkg::COORD_WIDTH-1] ? -s0_h_reg[k] : s0_h_reg[k];
        end
        for (int i = 0; i < NL; i++)
        begin
            mask_next[i] = int'(plane_count_reg) > i;
            for (int k = 0; k < 3; k++)
            begin
                fcull_pkg::norm_t        n;
                logic [NW-1:0]           nabs;
                n    = plane_reg[i][NW*k +: NW];
                nabs = n[NW-1] ? -n : n;
                dterm_next[i][k] = fcull_pkg::PROD_WIDTH'(n) *
                                   fcull_pkg::PROD_WIDTH'(s0_c_reg[k]);
                bterm_next[i][k] = fcull_pkg::PROD_WIDTH'(habs[k]) *
                                   fcull_pkg::PROD_WIDTH'(nabs);
            end
        end
    end

    logic              s1_valid_reg;
    logic              s1_op_reg;
    fcull_pkg::coord_t s1_r_reg;
    fcull_pkg::norm_t  s1_d_reg [NL];
    fcull_pkg::sprod_t s1_dterm_reg [NL][3];
    fcull_pkg::uprod_t s1_bterm_reg [NL][3];
    logic [NL-1:0]     s1_mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_valid_reg)
        begin
            s1_op_reg    <= s0_op_reg;
            s1_r_reg     <= s0_r_reg;
            s1_mask_reg  <= mask_next;
            s1_dterm_reg <= dterm_next;
            s1_bterm_reg <= bterm_next;
            for (int i = 0; i < NL; i++)
            begin
                s1_d_reg[i] <= plane_reg[i][3*NW +: NW];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: distance versus margin on each plane, then combine
    // ------------------------------------------------------------------
    logic [NL-1:0] reject;
    logic          visible_next;

    always_comb
    begin
        for (int i = 0; i < NL; i++)
        begin
            fcull_pkg::acc_t plane_dist;
            fcull_pkg::acc_t eff;
            plane_dist = fcull_pkg::ACC_WIDTH'(s1_dterm_reg[i][0]) +
                         fcull_pkg::ACC_WIDTH'(s1_dterm_reg[i][1]) +
                         fcull_pkg::ACC_WIDTH'(s1_dterm_reg[i][2]) -
                         (fcull_pkg::ACC_WIDTH'(s1_d_reg[i]) <<< fcull_pkg::NORM_FRAC);
            if (s1_op_reg == fcull_pkg::OP_BOX)
            begin
                eff = $signed(fcull_pkg::ACC_WIDTH'(s1_bterm_reg[i][0])) +
                      $signed(fcull_pkg::ACC_WIDTH'(s1_bterm_reg[i][1])) +
                      $signed(fcull_pkg::ACC_WIDTH'(s1_bterm_reg[i][2]));
            end
            else
            begin
                eff = fcull_pkg::ACC_WIDTH'(s1_r_reg) <<< fcull_pkg::NORM_FRAC;
            end
            // sums stay well inside the accumulator, so the sign is exact
            reject[i] = s1_mask_reg[i] && (plane_dist < -eff);
        end
        visible_next = ~|reject;
    end

    logic done_reg;
    logic visible_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            visible_reg <= visible_next;
        end
    end

    assign done    = done_reg;
    assign visible = visible_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // every accepted object yields a result after the input, product and result registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("accepted object produced no result on time");

    // no result without an object in the product stage
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(s1_valid_reg))
        else $error("result strobe without an object in flight");

    // no active planes means the object is reported visible
    a_no_planes: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_mask_reg == '0) |=> (done && visible))
        else $error("object rejected with no active planes");

    // active lanes form a contiguous run from plane 0
    a_mask_shape: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> ((s1_mask_reg & (s1_mask_reg + NL'(1))) == '0))
        else $error("active plane mask has a gap");

endmodule
